// ----- sv/mspd_pkg.sv -----
// shared constants, types and a saturation helper for the pd speed loop
`timescale 1ns / 1ps
`default_nettype none

package mspd_pkg;

    // defaults for the top level parameters
    localparam int DEF_RUN_INTERVAL = 10;
    localparam int DEF_HISTORY_LEN  = 4;

    // field widths
    localparam int POS_W  = 11;
    localparam int CNT_W  = 4;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int MUL_AW = 18;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [IDX_W-1:0] REG_SCALE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_KP     = 2'd2;
    localparam logic [IDX_W-1:0] REG_KD     = 2'd3;

    // register reset values
    localparam logic signed [15:0] RST_TARGET = 16'sd500;
    localparam logic [7:0]         RST_SCALE  = 8'd5;
    localparam logic [15:0]        RST_KP     = 16'd655;
    localparam logic [15:0]        RST_KD     = 16'd20;

    // loop constants
    localparam logic [10:0]        WRAP_SPAN  = 11'd1080;
    localparam logic signed [21:0] WRAP_LIMIT = 22'sd1500;
    localparam logic signed [24:0] DRIVE_MAX  = 25'sd255;
    localparam logic signed [35:0] Q12_BIAS   = 36'sd4095;

    // direction codes
    localparam logic [1:0] DIR_POS = 2'b10;
    localparam logic [1:0] DIR_NEG = 2'b01;

    typedef struct packed {
        logic [POS_W-1:0] newest;
        logic [POS_W-1:0] oldest;
    } t_hist_tap;

    function automatic logic signed [15:0] sat16(input logic signed [MUL_PW-1:0] v);
        logic signed [MUL_PW-1:0] hi;
        logic signed [MUL_PW-1:0] lo;
        hi = 35'sd32767;
        lo = -35'sd32768;
        if (v > hi) begin
            sat16 = 16'sh7fff;
        end else if (v < lo) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/mspd_tick.sv -----
// tick down-counter and position history shift line
`timescale 1ns / 1ps
`default_nettype none

module mspd_tick
    import mspd_pkg::*;
#(
    parameter int RUN_INTERVAL = DEF_RUN_INTERVAL,
    parameter int HISTORY_LEN  = DEF_HISTORY_LEN
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [POS_W-1:0] i_position,
    output logic                  o_fire,
    output t_hist_tap             o_tap
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [POS_W-1:0] r_hist [0:HISTORY_LEN];

    // countdown after this beat, fires when it reaches zero
    assign n_cnt  = r_cnt - 1'b1;
    assign o_fire = (n_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_W'(RUN_INTERVAL);
        end else if (i_accept) begin
            r_cnt <= o_fire ? CNT_W'(RUN_INTERVAL) : n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= HISTORY_LEN; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_accept && o_fire) begin
            for (int k = 0; k < HISTORY_LEN; k++) begin
                r_hist[k] <= r_hist[k+1];
            end
            r_hist[HISTORY_LEN] <= i_position;
        end
    end

    assign o_tap.newest = r_hist[HISTORY_LEN];
    assign o_tap.oldest = r_hist[0];

endmodule

`default_nettype wire

// ----- sv/mspd_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module mspd_mul
    import mspd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [MUL_AW-1:0] i_a,
    input  wire logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0]      o_p
);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= i_a * i_b;
        end
    end

endmodule

`default_nettype wire

// ----- sv/motor_speed_pd_loop_unit.sv -----
// pd speed loop: tick counter, history, sequencer over one shared multiplier
// a firing beat gives its result through the states speed to drive, then the result register
// non-firing beats are taken one per cycle while the sequencer is idle and give no result
// a firing beat holds the input side for one pass of the sequencer through the shared
//   multiplier, longer if the last result is still waiting
// synchronous active-low reset: registers to defaults, history and loop state
//   cleared, countdown reloaded
`timescale 1ns / 1ps
`default_nettype none

module motor_speed_pd_loop_unit
    import mspd_pkg::*;
#(
    parameter int RUN_INTERVAL = DEF_RUN_INTERVAL,
    parameter int HISTORY_LEN  = DEF_HISTORY_LEN
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration writes
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    // input beats
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [POS_W-1:0] i_position,
    // result beats
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_direction,
    output logic [7:0]            o_duty
);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SPEED = 4'd1;  // diff * dt
    localparam logic [3:0] ST_WMUL  = 4'd2;  // capture speed, 1080 * dt
    localparam logic [3:0] ST_WRAP  = 4'd3;  // wrap correction
    localparam logic [3:0] ST_ERR   = 4'd4;  // saturated error
    localparam logic [3:0] ST_DMUL  = 4'd5;  // (err - prev) * dt
    localparam logic [3:0] ST_DSAT  = 4'd6;  // saturate deriv, err * kp
    localparam logic [3:0] ST_KDMUL = 4'd7;  // capture p term, deriv * kd
    localparam logic [3:0] ST_SUM   = 4'd8;  // p + d
    localparam logic [3:0] ST_TRUNC = 4'd9;  // q12 shift toward zero
    localparam logic [3:0] ST_DRIVE = 4'd10; // add previous drive, clamp, emit

    // configuration registers
    logic signed [15:0] r_target;
    logic [7:0]         r_scale;
    logic [15:0]        r_kp;
    logic [15:0]        r_kd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= RST_TARGET;
            r_scale  <= RST_SCALE;
            r_kp     <= RST_KP;
            r_kd     <= RST_KD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET: r_target <= i_cfg_data;
                REG_SCALE:  r_scale  <= i_cfg_data[7:0];
                REG_KP:     r_kp     <= i_cfg_data;
                REG_KD:     r_kd     <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // tick counter and history
    logic      in_acc;
    logic      fire;
    t_hist_tap tap;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    mspd_tick #(
        .RUN_INTERVAL (RUN_INTERVAL),
        .HISTORY_LEN  (HISTORY_LEN)
    ) u_tick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_acc),
        .i_position (i_position),
        .o_fire     (fire),
        .o_tap      (tap)
    );

    // shared multiplier and its operand select
    logic                     mul_en;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] prod;

    logic signed [11:0] pos_diff;
    logic signed [16:0] err_step;
    logic signed [MUL_BW-1:0] scale_b;

    logic signed [21:0] r_speed;
    logic signed [15:0] r_err;
    logic signed [15:0] r_der;
    logic signed [35:0] r_acc;
    logic signed [23:0] r_pd;
    logic signed [15:0] r_prev_err;
    logic signed [8:0]  r_prev_drive;

    assign pos_diff = $signed({1'b0, tap.newest}) - $signed({1'b0, tap.oldest});
    assign err_step = 17'(r_err) - 17'(r_prev_err);
    assign scale_b  = $signed({9'b0, r_scale});

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            ST_SPEED: begin
                mul_a = MUL_AW'(pos_diff);
                mul_b = scale_b;
            end
            ST_WMUL: begin
                mul_a = $signed({7'b0, WRAP_SPAN});
                mul_b = scale_b;
            end
            ST_DMUL: begin
                mul_a = MUL_AW'(err_step);
                mul_b = scale_b;
            end
            ST_DSAT: begin
                mul_a = MUL_AW'(r_err);
                mul_b = $signed({1'b0, r_kp});
            end
            ST_KDMUL: begin
                mul_a = MUL_AW'(r_der);
                mul_b = $signed({1'b0, r_kd});
            end
            default: mul_en = 1'b0;
        endcase
    end

    mspd_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // datapath steps between multiplies
    logic signed [21:0] wrap_amt;
    logic signed [21:0] speed_fix;
    logic signed [22:0] err_full;
    logic signed [35:0] acc_biased;
    logic signed [24:0] drive_sum;
    logic signed [8:0]  drive;
    logic               out_free;

    assign wrap_amt = 22'(prod[19:0]);

    always_comb begin
        if (r_speed < -WRAP_LIMIT) begin
            speed_fix = r_speed + wrap_amt;
        end else if (r_speed > WRAP_LIMIT) begin
            speed_fix = r_speed - wrap_amt;
        end else begin
            speed_fix = r_speed;
        end
    end

    assign err_full   = 23'(r_target) - 23'(r_speed);
    // bias negatives so the shift truncates toward zero
    assign acc_biased = r_acc + (r_acc[35] ? Q12_BIAS : 36'sd0);
    assign drive_sum  = 25'(r_pd) + 25'(r_prev_drive);

    always_comb begin
        if (drive_sum > DRIVE_MAX) begin
            drive = 9'sd255;
        end else if (drive_sum < -DRIVE_MAX) begin
            drive = -9'sd255;
        end else begin
            drive = drive_sum[8:0];
        end
    end

    assign out_free = !o_out_valid || i_out_ready;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc && fire) n_state = ST_SPEED;
            ST_SPEED: n_state = ST_WMUL;
            ST_WMUL:  n_state = ST_WRAP;
            ST_WRAP:  n_state = ST_ERR;
            ST_ERR:   n_state = ST_DMUL;
            ST_DMUL:  n_state = ST_DSAT;
            ST_DSAT:  n_state = ST_KDMUL;
            ST_KDMUL: n_state = ST_SUM;
            ST_SUM:   n_state = ST_TRUNC;
            ST_TRUNC: n_state = ST_DRIVE;
            ST_DRIVE: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_WMUL:  r_speed <= prod[21:0];
            ST_WRAP:  r_speed <= speed_fix;
            ST_ERR:   r_err   <= sat16(MUL_PW'(err_full));
            ST_DSAT:  r_der   <= sat16(prod);
            ST_KDMUL: r_acc   <= 36'(prod);
            ST_SUM:   r_acc   <= r_acc + 36'(prod);
            ST_TRUNC: r_pd    <= acc_biased[35:12];
            default:  ;
        endcase
    end

    // loop state carried between control steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err   <= '0;
            r_prev_drive <= '0;
        end else if (r_state == ST_DRIVE && out_free) begin
            r_prev_err   <= r_err;
            r_prev_drive <= drive;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_DRIVE && out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRIVE && out_free) begin
            if (drive > 9'sd0) begin
                o_direction <= DIR_POS;
                o_duty      <= drive[7:0];
            end else begin
                o_direction <= DIR_NEG;
                o_duty      <= 8'(-drive);
            end
        end
    end

    // checks
    a_fire_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && fire) |=> (r_state == ST_SPEED))
        else $error("firing beat did not start the sequencer");

    a_drive_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRIVE && out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished control step did not present a result");

    a_prev_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_drive <= 9'sd255) && (r_prev_drive >= -9'sd255))
        else $error("stored drive outside saturation range");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_direction == DIR_POS) || (o_direction == DIR_NEG)))
        else $error("result carries an unknown direction code");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for the pd speed loop: predicts every drive beat and checks it against the block
`timescale 1ns / 1ps

module tb_top;
    import mspd_pkg::*;

    localparam int HIST_DEPTH   = DEF_HISTORY_LEN + 1;
    localparam int SETTLE_TICKS = 24;      // quiet stretch after the last drive beat returns, with margin
    localparam int LONG_HOLD    = 300;     // receiver back-pressure stretch
    localparam int CYCLE_LIMIT  = 100000;  // far above the slowest legal run

    typedef struct packed {
        logic [1:0] direction;
        logic [7:0] duty;
    } t_drive_cmd;

    // clock, reset and block inputs, all known from time zero
    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx  = REG_TARGET;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic [POS_W-1:0] i_position = '0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [1:0]       o_direction;
    logic [7:0]       o_duty;

    // encoder ticks waiting for the driver, drive beats waiting for the block
    logic [POS_W-1:0] pending_ticks[$];
    t_drive_cmd       expected_drive[$];

    // controller copy: registers as last written
    logic signed [15:0] cfg_target;
    logic [7:0]         cfg_scale;
    logic [15:0]        cfg_kp;
    logic [15:0]        cfg_kd;

    // controller copy: loop state
    logic [3:0]       tick_left;
    logic [POS_W-1:0] pos_hist [HIST_DEPTH];
    longint           last_err;
    longint           last_drive;

    // idling knobs, changed only on the falling edge
    int snd_gap_max   = 0;
    int rcv_stall_max = 0;
    int hold_trigger  = 0;

    int error_count = 0;
    int cycle_count = 0;

    // trajectory of a simulated shaft for well-formed position streams
    int shaft_pos = 0;
    int shaft_vel = 7;

    motor_speed_pd_loop_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_position (i_position),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_direction(o_direction),
        .o_duty     (o_duty)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // one system tick through the controller; a control tick queues its drive beat
    task automatic advance_controller(input logic [POS_W-1:0] pos);
        longint dt, spd, err_v, der_v, pd_v, drv;
        t_drive_cmd cmd;
        tick_left = tick_left - 4'd1;
        if (tick_left != 4'd0) begin
            return;
        end
        tick_left = 4'(DEF_RUN_INTERVAL);
        for (int k = 0; k < HIST_DEPTH - 1; k++) begin
            pos_hist[k] = pos_hist[k + 1];
        end
        pos_hist[HIST_DEPTH - 1] = pos;

        dt  = longint'(cfg_scale);
        spd = (longint'(pos_hist[HIST_DEPTH - 1]) - longint'(pos_hist[0])) * dt;
        // wrap of the encoder shows up as an implausibly fast speed
        if (spd < -1500) begin
            spd = spd + 1080 * dt;
        end else if (spd > 1500) begin
            spd = spd - 1080 * dt;
        end
        err_v = clip(longint'(cfg_target) - spd, -32768, 32767);
        der_v = clip((err_v - last_err) * dt, -32768, 32767);
        // q12 gains, signed division truncates toward zero
        pd_v  = (err_v * longint'(cfg_kp) + der_v * longint'(cfg_kd)) / 4096;
        drv   = clip(pd_v + last_drive, -255, 255);
        last_err   = err_v;
        last_drive = drv;

        if (drv > 0) begin
            cmd.direction = DIR_POS;
            cmd.duty      = 8'(drv);
        end else begin
            cmd.direction = DIR_NEG;
            cmd.duty      = 8'(-drv);
        end
        expected_drive.push_back(cmd);
    endtask

    // driver: offers queued ticks, draws a random idle gap per beat, bounded by snd_gap_max
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_controller(i_position);
            end
            // slot is free unless the current beat is still waiting
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    i_position <= pending_ticks.pop_front();
                    i_in_valid <= 1'b1;
                    gap_left   <= $urandom_range(0, snd_gap_max);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each drive beat, stalls per beat and on request for a long stretch
    int stall_left = 0;
    int hold_left  = 0;
    int hold_seen  = 0;
    always @(posedge i_clk) begin
        int s_next;
        int h_next;
        t_drive_cmd want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
            hold_seen   <= hold_trigger;
        end else begin
            s_next = stall_left;
            h_next = hold_left;
            if (o_out_valid && i_out_ready) begin
                if (expected_drive.size() == 0) begin
                    report_mismatch($sformatf("drive beat dir=%0d duty=%0d with none expected",
                                              o_direction, o_duty));
                end else begin
                    want = expected_drive.pop_front();
                    if (o_direction !== want.direction) begin
                        report_mismatch($sformatf("direction %0d, expected %0d",
                                                  o_direction, want.direction));
                    end
                    if (o_duty !== want.duty) begin
                        report_mismatch($sformatf("duty %0d, expected %0d",
                                                  o_duty, want.duty));
                    end
                end
                s_next = $urandom_range(0, rcv_stall_max);
            end else if (o_out_valid && s_next > 0) begin
                // stall counts only while a beat is actually waiting
                s_next = s_next - 1;
            end
            if (hold_trigger != hold_seen) begin
                hold_seen <= hold_trigger;
                h_next = LONG_HOLD;
            end else if (h_next > 0) begin
                h_next = h_next - 1;
            end
            stall_left  <= s_next;
            hold_left   <= h_next;
            i_out_ready <= (s_next == 0) && (h_next == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d drive beats outstanding",
                     cycle_count, expected_drive.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // waits until every tick is taken and every drive beat has come back
    task automatic wait_for_idle();
        while (!(pending_ticks.size() == 0 && !i_in_valid && expected_drive.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_TARGET: cfg_target = data;
            REG_SCALE:  cfg_scale  = data[7:0];
            REG_KP:     cfg_kp     = data;
            REG_KD:     cfg_kd     = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // new loop setting, written only once the block has gone quiet
    task automatic program_loop(input logic [15:0] target, input logic [7:0] scale,
                                input logic [15:0] kp, input logic [15:0] kd);
        wait_for_idle();
        write_reg(REG_TARGET, target);
        write_reg(REG_SCALE, {8'($urandom), scale});  // upper byte is don't-care
        write_reg(REG_KP, kp);
        write_reg(REG_KD, kd);
        @(negedge i_clk);
    endtask

    // mostly a plausible shaft trajectory, sometimes raw noise over all 11 bits
    task automatic feed_ticks(input int n);
        logic [POS_W-1:0] pos;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                pos = 11'($urandom_range(0, 2047));
            end else begin
                if ($urandom_range(0, 15) == 0) begin
                    shaft_vel = int'($urandom_range(0, 80)) - 40;
                end
                shaft_pos = (shaft_pos + shaft_vel + 1080) % 1080;
                pos = 11'(shaft_pos);
            end
            pending_ticks.push_back(pos);
        end
    endtask

    task automatic set_idling(input int snd, input int rcv);
        @(negedge i_clk);
        snd_gap_max   = snd;
        rcv_stall_max = rcv;
    endtask

    initial begin
        logic [15:0] tgt;
        logic [15:0] kp;
        logic [15:0] kd;

        // controller copy starts from the reset state
        cfg_target = 16'sd500;
        cfg_scale  = 8'd5;
        cfg_kp     = 16'd655;
        cfg_kd     = 16'd20;
        tick_left  = 4'(DEF_RUN_INTERVAL);
        foreach (pos_hist[k]) begin
            pos_hist[k] = '0;
        end
        last_err   = 0;
        last_drive = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset gains, the control ticks land on the position extremes;
        // first one sees 2047 above the encoder range and crosses the wrap limit
        set_idling(0, 0);
        pending_ticks.push_back(11'd0);
        pending_ticks.push_back(11'd2047);
        pending_ticks.push_back(11'd1079);
        pending_ticks.push_back(11'd1080);
        for (int b = 0; b < 5; b++) begin
            pending_ticks.push_back(11'(1 << b));
        end
        pending_ticks.push_back(11'd2047);   // control tick
        for (int b = 10; b > 4; b--) begin
            pending_ticks.push_back(11'(1 << b));
        end
        pending_ticks.push_back(11'd1080);
        pending_ticks.push_back(11'd1079);
        pending_ticks.push_back(11'd1078);
        pending_ticks.push_back(11'd0);      // control tick
        wait_for_idle();

        // reset gains with idling on both sides
        set_idling(4, 4);
        feed_ticks(30);
        wait_for_idle();

        // receiver holds off while the sender streams, input side must back up
        set_idling(0, 0);
        hold_trigger = hold_trigger + 1;
        feed_ticks(120);
        // sender pauses until all drive beats are back, then resumes
        wait_for_idle();
        set_idling(2, 4);
        feed_ticks(30);

        // largest target, scale and gains: huge pd term, drive pinned at the top
        program_loop(16'h7fff, 8'd255, 16'hffff, 16'hffff);
        set_idling(4, 0);
        feed_ticks(100);

        // most negative target, unit scale, zero gains: drive frozen where it was
        program_loop(16'h8000, 8'd1, 16'h0000, 16'h0000);
        set_idling(0, 4);
        feed_ticks(80);

        // zero time scale: speed and derivative vanish, only the set point acts
        tgt = 16'(int'($urandom_range(0, 4000)) - 2000);
        program_loop(tgt, 8'd0, 16'($urandom_range(0, 8191)), 16'($urandom));
        set_idling(4, 4);
        feed_ticks(80);

        // random settings, gains mostly moderate so the drive moves inside its range
        for (int p = 0; p < 5; p++) begin
            tgt = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(0, 3000)) - 1500);
            kp  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191));
            kd  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
            program_loop(tgt, 8'($urandom_range(0, 255)), kp, kd);
            if (p % 2 == 0) begin
                set_idling(4, 4);
            end else begin
                set_idling(0, 4 * (p % 4 == 1));
            end
            feed_ticks(100);
        end

        wait_for_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
